>>> design/lob_pkg.sv
// Shared types and constants for the order book matcher.
// No dependencies.
package lob_pkg;

  localparam int unsigned BookSlots = 32;
  localparam int unsigned MaxTrades = 32;
  localparam int unsigned SlotW = $clog2(BookSlots);
  localparam int unsigned TradeW = $clog2(MaxTrades + 1);

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;
  localparam logic [1:0] OpModify = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StDup = 2'd3;

  localparam logic KindTrade = 1'b0;
  localparam logic KindDone = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] req_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] fill_price;
    logic [31:0] fill_qty;
    logic [1:0]  status;
    logic [31:0] top_bid;
    logic [31:0] top_ask;
    logic        bid_present;
    logic        ask_present;
    logic        last;
  } out_word_t;

  // Candidate travelling along the scan chain.
  typedef struct packed {
    logic        found;
    logic [SlotW-1:0] slot;
    logic [31:0] price;
    logic [31:0] age;
    logic [31:0] qty;
    logic [31:0] id;
  } cand_t;

  // Command from the controller to every slot cell.
  typedef struct packed {
    logic        write;
    logic [SlotW-1:0] wslot;
    logic        wside;
    logic [31:0] wid;
    logic [31:0] wprice;
    logic [31:0] wqty;
    logic [31:0] wage;
    logic        kill;
    logic [SlotW-1:0] kslot;
    logic        sub_b;
    logic [SlotW-1:0] bslot;
    logic        sub_a;
    logic [SlotW-1:0] aslot;
    logic [31:0] sub_q;
  } cell_cmd_t;

endpackage

>>> design/lob_cell.sv
// One book slot plus one stage of the scan chain.
// Depends on lob_pkg.
module lob_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lob_pkg::SlotW-1:0]  my_slot,
  input  lob_pkg::cell_cmd_t         cmd,
  input  logic [31:0]                key_id,
  input  lob_pkg::cand_t             bid_in,
  input  lob_pkg::cand_t             ask_in,
  input  lob_pkg::cand_t             hit_in,
  input  logic                       free_in_found,
  input  logic [lob_pkg::SlotW-1:0]  free_in_slot,
  output lob_pkg::cand_t             bid_out,
  output lob_pkg::cand_t             ask_out,
  output lob_pkg::cand_t             hit_out,
  output logic                       free_out_found,
  output logic [lob_pkg::SlotW-1:0]  free_out_slot
);

  logic        valid_r;
  logic        side_r;
  logic [31:0] id_r, price_r, qty_r, age_r;
  logic [31:0] qty_nxt;
  lob_pkg::cand_t bid_nxt, ask_nxt, hit_nxt, mine;
  logic free_nxt_f;
  logic [lob_pkg::SlotW-1:0] free_nxt_s;

  always_comb begin
    qty_nxt = qty_r;
    if (cmd.sub_b && cmd.bslot == my_slot) qty_nxt = qty_nxt - cmd.sub_q;
    if (cmd.sub_a && cmd.aslot == my_slot) qty_nxt = qty_nxt - cmd.sub_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.write && cmd.wslot == my_slot) begin
      valid_r <= 1'b1;
    end else if (cmd.kill && cmd.kslot == my_slot) begin
      valid_r <= 1'b0;
    end else if ((cmd.sub_b && cmd.bslot == my_slot) || (cmd.sub_a && cmd.aslot == my_slot)) begin
      valid_r <= (qty_nxt != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd.wslot == my_slot) begin
      side_r  <= cmd.wside;
      id_r    <= cmd.wid;
      price_r <= cmd.wprice;
      qty_r   <= cmd.wqty;
      age_r   <= cmd.wage;
    end else begin
      qty_r <= qty_nxt;
    end
  end

  always_comb begin
    mine = '{found: 1'b1, slot: my_slot, price: price_r, age: age_r, qty: qty_r, id: id_r};
    bid_nxt = bid_in;
    if (valid_r && !side_r) begin
      if (!bid_in.found || price_r > bid_in.price ||
          (price_r == bid_in.price && age_r < bid_in.age)) bid_nxt = mine;
    end
    ask_nxt = ask_in;
    if (valid_r && side_r) begin
      if (!ask_in.found || price_r < ask_in.price ||
          (price_r == ask_in.price && age_r < ask_in.age)) ask_nxt = mine;
    end
    hit_nxt = hit_in;
    if (!hit_in.found && valid_r && id_r == key_id) begin
      hit_nxt = mine;
      hit_nxt.qty = {31'd0, side_r};
    end
    free_nxt_f = free_in_found;
    free_nxt_s = free_in_slot;
    if (!free_in_found && !valid_r) begin
      free_nxt_f = 1'b1;
      free_nxt_s = my_slot;
    end
  end

  always_ff @(posedge clk) begin
    bid_out <= bid_nxt;
    ask_out <= ask_nxt;
    hit_out <= hit_nxt;
    free_out_found <= free_nxt_f;
    free_out_slot <= free_nxt_s;
  end

endmodule

>>> design/limit_order_book_matcher_unit.sv
// Top level of the order book matcher: slot cell chain and request sequencer.
// Depends on lob_pkg and lob_cell.
//
// Channel | Dir | Ports                          | Word
// in      | in  | in_valid, in_stall, in_data    | lob_pkg::in_word_t
// out     | out | out_valid, out_stall, out_data | lob_pkg::out_word_t
//
// One request at a time. Each scan walks the BookSlots-cell chain; a request
// takes one lookup scan, one scan after the update and one more
// scan per trade.
// Reset (rst_n low, synchronous) empties the book and clears the counter.
// out_stall holds the result register and pauses the sequencer.
module limit_order_book_matcher_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lob_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lob_pkg::out_word_t  out_data
);

  localparam int unsigned N = lob_pkg::BookSlots;
  localparam int unsigned CW = $clog2(N + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_APPLY, S_SCAN, S_MATCH, S_EMIT
  } state_t;

  state_t state_r;
  lob_pkg::in_word_t req_r;
  logic [CW-1:0] cnt_r;
  logic [lob_pkg::TradeW-1:0] ntr_r;
  logic [31:0] arrival_r;
  logic [1:0] status_r;
  logic match_r;
  logic out_valid_r;
  lob_pkg::out_word_t out_r;
  lob_pkg::out_word_t out_nxt;
  lob_pkg::cell_cmd_t cmd;

  lob_pkg::cand_t bid_c [N+1];
  lob_pkg::cand_t ask_c [N+1];
  lob_pkg::cand_t hit_c [N+1];
  logic free_f [N+1];
  logic [lob_pkg::SlotW-1:0] free_s [N+1];

  assign bid_c[0] = '0;
  assign ask_c[0] = '0;
  assign hit_c[0] = '0;
  assign free_f[0] = 1'b0;
  assign free_s[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lob_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_slot(lob_pkg::SlotW'(g)), .cmd(cmd),
      .key_id(req_r.req_id),
      .bid_in(bid_c[g]), .ask_in(ask_c[g]), .hit_in(hit_c[g]),
      .free_in_found(free_f[g]), .free_in_slot(free_s[g]),
      .bid_out(bid_c[g+1]), .ask_out(ask_c[g+1]), .hit_out(hit_c[g+1]),
      .free_out_found(free_f[g+1]), .free_out_slot(free_s[g+1])
    );
  end

  lob_pkg::cand_t bb, ba, hh;
  logic [31:0] q;
  assign bb = bid_c[N];
  assign ba = ask_c[N];
  assign hh = hit_c[N];
  assign q = (bb.qty < ba.qty) ? bb.qty : ba.qty;
  logic scan_done;
  assign scan_done = (cnt_r == CW'(N));
  logic crosses;
  assign crosses = bb.found && ba.found && (bb.price >= ba.price) &&
                   (ntr_r != lob_pkg::TradeW'(lob_pkg::MaxTrades));

  always_comb begin
    cmd = '0;
    cmd.wid = req_r.req_id;
    cmd.wprice = req_r.price;
    cmd.wqty = req_r.quantity;
    cmd.wage = arrival_r;
    cmd.sub_q = q;
    cmd.bslot = bb.slot;
    cmd.aslot = ba.slot;
    cmd.kslot = hh.slot;
    cmd.wside = req_r.side;
    if (state_r == S_APPLY) begin
      case (req_r.opcode)
        lob_pkg::OpAdd: begin
          cmd.wslot = free_s[N];
          cmd.write = !hh.found && (req_r.quantity != 32'd0) && free_f[N];
        end
        lob_pkg::OpCancel: cmd.kill = hh.found;
        lob_pkg::OpModify: begin
          cmd.wslot = hh.slot;
          cmd.wside = hh.qty[0];
          cmd.write = hh.found && (req_r.quantity != 32'd0);
          cmd.kill = hh.found && (req_r.quantity == 32'd0);
        end
        default: ;
      endcase
    end else if (state_r == S_MATCH && match_r && crosses && !out_valid_r) begin
      cmd.sub_b = 1'b1;
      cmd.sub_a = 1'b1;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (match_r && crosses) begin
      out_nxt.result_kind = lob_pkg::KindTrade;
      out_nxt.buy_id = bb.id;
      out_nxt.sell_id = ba.id;
      out_nxt.fill_price = (bb.age < ba.age) ? bb.price : ba.price;
      out_nxt.fill_qty = q;
    end else begin
      out_nxt.result_kind = lob_pkg::KindDone;
      out_nxt.status = status_r;
      out_nxt.top_bid = bb.found ? bb.price : 32'd0;
      out_nxt.top_ask = ba.found ? ba.price : 32'd0;
      out_nxt.bid_present = bb.found;
      out_nxt.ask_present = ba.found;
      out_nxt.last = 1'b1;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      arrival_r <= '0;
      cnt_r <= '0;
      ntr_r <= '0;
      status_r <= lob_pkg::StDone;
      match_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            cnt_r <= '0;
            ntr_r <= '0;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          cnt_r <= cnt_r + CW'(1);
          if (scan_done) state_r <= S_APPLY;
        end
        S_APPLY: begin
          status_r <= lob_pkg::StDone;
          match_r <= 1'b0;
          case (req_r.opcode)
            lob_pkg::OpAdd: begin
              if (hh.found) status_r <= lob_pkg::StDup;
              else if (req_r.quantity != 32'd0 && !free_f[N]) status_r <= lob_pkg::StFull;
              match_r <= cmd.write;
            end
            lob_pkg::OpCancel: if (!hh.found) status_r <= lob_pkg::StNotFound;
            lob_pkg::OpModify: begin
              if (!hh.found) status_r <= lob_pkg::StNotFound;
              match_r <= cmd.write;
            end
            default: ;
          endcase
          if (cmd.write) arrival_r <= arrival_r + 32'd1;
          cnt_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          cnt_r <= cnt_r + CW'(1);
          if (scan_done) state_r <= S_MATCH;
        end
        S_MATCH: begin
          if (!out_valid_r) begin
            out_r <= out_nxt;
            out_valid_r <= 1'b1;
            if (match_r && crosses) begin
              ntr_r <= ntr_r + lob_pkg::TradeW'(1);
              cnt_r <= '0;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_valid_r && !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_trade_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ntr_r <= lob_pkg::TradeW'(lob_pkg::MaxTrades)) else $error("trade cap exceeded");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> (state_r == S_IDLE))
    else $error("sequencer not idle after last word");
  a_trade_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == lob_pkg::KindTrade) |->
    (out_data.fill_qty != 32'd0)) else $error("empty trade");
`endif

endmodule
